// ===== hdl/iou_pkg.sv =====
// Shared constants and types for the IoU track association block.
package iou_pkg;

  // Default sizing of the track table and the box coordinates.
  localparam int unsigned TRACK_SLOTS_DEF = 16;
  localparam int unsigned COORD_BITS_DEF  = 12;

  // Fixed field widths of the result interface.
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned MISS_W  = 8;
  localparam int unsigned CAR_W   = 16;
  localparam int unsigned LIMIT_W = 9;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_NEW_IOU   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_IOU = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIM  = 2'd2;

  localparam logic [LIMIT_W-1:0] NEW_IOU_RST   = 9'd77;
  localparam logic [LIMIT_W-1:0] MATCH_IOU_RST = 9'd128;
  localparam logic [MISS_W-1:0]  MISS_LIM_RST  = 8'd10;

  // Input command codes.
  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_FRAME  = 1'b1;

  // Compare request issued to the IoU unit with its table slot.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] slot;
  } iou_req_t;

  // Compare outcome returned by the IoU unit.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] slot;
    logic             hit_new;
    logic             hit_match;
  } iou_hit_t;

endpackage

// ===== hdl/iou_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module iou_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/iou_unit.sv =====
// Pipelined IoU threshold compare of one detection against one track per cycle.
module iou_unit #(
  parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iou_pkg::iou_req_t             req_i,
  input  logic [COORD_BITS-1:0]         det_x_i,
  input  logic [COORD_BITS-1:0]         det_y_i,
  input  logic [COORD_BITS-1:0]         det_w_i,
  input  logic [COORD_BITS-1:0]         det_h_i,
  input  logic [COORD_BITS-1:0]         trk_x_i,
  input  logic [COORD_BITS-1:0]         trk_y_i,
  input  logic [COORD_BITS-1:0]         trk_w_i,
  input  logic [COORD_BITS-1:0]         trk_h_i,
  input  logic [iou_pkg::LIMIT_W-1:0]   new_limit_i,
  input  logic [iou_pkg::LIMIT_W-1:0]   match_limit_i,
  output iou_pkg::iou_hit_t             hit_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = 2 * CB;
  localparam int unsigned UW = AW + 1;
  localparam int unsigned PW = iou_pkg::LIMIT_W + UW;

  // Overlap length of two half-open intervals, zero when they do not meet.
  function automatic logic [CB-1:0] axis_ov(input logic [CB-1:0] p0, input logic [CB-1:0] l0,
                                            input logic [CB-1:0] p1, input logic [CB-1:0] l1);
    logic [CB:0] lo;
    logic [CB:0] e0;
    logic [CB:0] e1;
    logic [CB:0] hi;
    lo = (p0 > p1) ? {1'b0, p0} : {1'b0, p1};
    e0 = {1'b0, p0} + {1'b0, l0};
    e1 = {1'b0, p1} + {1'b0, l1};
    hi = (e0 < e1) ? e0 : e1;
    axis_ov = (hi > lo) ? CB'(hi - lo) : '0;
  endfunction

  // Stage 1: axis overlaps and side lengths.
  logic                      v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [iou_pkg::IDX_W-1:0] s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [CB-1:0]             ox_q, oy_q, dw_q, dh_q, tw_q, th_q;
  // Stage 2: areas.
  logic [AW-1:0]             inter2_q, darea_q, tarea_q;
  // Stage 3: union.
  logic [AW-1:0]             inter3_q;
  logic [UW-1:0]             uni_q;
  // Stage 4: scaled products.
  logic [PW-1:0]             scaled_q, pnew_q, pmatch_q;
  logic                      uni_nz_q;
  // Stage 5: compare flags.
  logic                      hit_new_q, hit_match_q;

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    s1_q <= req_i.slot;
    ox_q <= axis_ov(det_x_i, det_w_i, trk_x_i, trk_w_i);
    oy_q <= axis_ov(det_y_i, det_h_i, trk_y_i, trk_h_i);
    dw_q <= det_w_i;
    dh_q <= det_h_i;
    tw_q <= trk_w_i;
    th_q <= trk_h_i;

    s2_q     <= s1_q;
    inter2_q <= AW'(ox_q) * AW'(oy_q);
    darea_q  <= AW'(dw_q) * AW'(dh_q);
    tarea_q  <= AW'(tw_q) * AW'(th_q);

    s3_q     <= s2_q;
    inter3_q <= inter2_q;
    uni_q    <= UW'(darea_q) + UW'(tarea_q) - UW'(inter2_q);

    s4_q     <= s3_q;
    scaled_q <= PW'({inter3_q, 8'b0});
    pnew_q   <= PW'(new_limit_i) * PW'(uni_q);
    pmatch_q <= PW'(match_limit_i) * PW'(uni_q);
    uni_nz_q <= (uni_q != '0);

    s5_q        <= s4_q;
    hit_new_q   <= uni_nz_q && (scaled_q > pnew_q);
    hit_match_q <= uni_nz_q && (scaled_q > pmatch_q);
  end

  assign hit_o.valid     = v5_q;
  assign hit_o.slot      = s5_q;
  assign hit_o.hit_new   = hit_new_q;
  assign hit_o.hit_match = hit_match_q;

endmodule

// ===== hdl/iou_track_association.sv =====
// A detection is compared against every stored track (one RAM read per track, a five-stage IoU
// compare, then the decision) and loads its single result, with no reads when the table is empty.
// End of frame: each stored track is read once the output is free, then updated and emitted.
// Throughput: one request at a time; a new request is taken once the previous one has finished.
// Reset clears the track count, car total, matched and fresh flags and sets the thresholds to
// their defaults; the box memory is not cleared and only slots below the track count are read.
module iou_track_association #(
  parameter int unsigned TRACK_SLOTS = iou_pkg::TRACK_SLOTS_DEF,
  parameter int unsigned COORD_BITS  = iou_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port.
  input  logic                            cfg_we_i,
  input  logic [iou_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [iou_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [COORD_BITS-1:0]           box_x_i,
  input  logic [COORD_BITS-1:0]           box_y_i,
  input  logic [COORD_BITS-1:0]           box_width_i,
  input  logic [COORD_BITS-1:0]           box_height_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_new_o,
  output logic                            table_full_o,
  output logic [iou_pkg::IDX_W-1:0]       entry_index_o,
  output logic [COORD_BITS-1:0]           entry_x_o,
  output logic [COORD_BITS-1:0]           entry_y_o,
  output logic [COORD_BITS-1:0]           entry_width_o,
  output logic [COORD_BITS-1:0]           entry_height_o,
  output logic [iou_pkg::MISS_W-1:0]      miss_count_o,
  output logic                            visible_o,
  output logic                            entry_valid_o,
  output logic [iou_pkg::CAR_W-1:0]       car_total_o,
  output logic                            last_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned SW     = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int unsigned CW     = $clog2(TRACK_SLOTS + 1);
  localparam int unsigned MW     = iou_pkg::MISS_W;
  localparam int unsigned WORD_W = 4 * CB + MW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FRD,
    ST_FWR,
    ST_FEMPTY
  } state_e;

  state_e                          state_q, state_d;
  logic [CB-1:0]                   det_x_q, det_y_q, det_w_q, det_h_q;
  logic [CW-1:0]                   rd_idx_q, rd_idx_d;
  logic [CW-1:0]                   res_cnt_q, res_cnt_d;
  logic [CW-1:0]                   used_q, used_d;
  logic [iou_pkg::CAR_W-1:0]       cars_q, cars_d;
  logic                            known_q, known_d;
  logic [TRACK_SLOTS-1:0]          matched_q, matched_d;
  logic [TRACK_SLOTS-1:0]          fresh_q, fresh_d;
  logic                            scan_vld_q, scan_vld_d;
  logic [SW-1:0]                   scan_slot_q;
  logic [iou_pkg::LIMIT_W-1:0]     new_lim_q, match_lim_q;
  logic [MW-1:0]                   miss_lim_q;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic                            load_out;
  logic                            is_new_q, is_new_d;
  logic                            full_q, full_d;
  logic [iou_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [CB-1:0]                   ox_q, ox_d, oy_q, oy_d, ow_q, ow_d, oh_q, oh_d;
  logic [MW-1:0]                   omiss_q, omiss_d;
  logic                            vis_q, vis_d;
  logic                            evalid_q, evalid_d;
  logic [iou_pkg::CAR_W-1:0]       ocars_q, ocars_d;
  logic                            last_q, last_d;

  // Track memory port signals.
  logic                            ram_we, ram_re;
  logic [SW-1:0]                   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]               ram_wdata, ram_rdata;
  logic [CB-1:0]                   trk_x, trk_y, trk_w, trk_h;
  logic [MW-1:0]                   trk_miss, miss_new;

  iou_pkg::iou_req_t               req;
  iou_pkg::iou_hit_t               hit;
  logic [SW-1:0]                   hit_slot, cur_slot;
  logic                            out_free;
  logic [iou_pkg::CAR_W-1:0]       cars_inc;

  // Track boxes and miss counters share one memory word.
  iou_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TRACK_SLOTS)
  ) u_track_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign {trk_x, trk_y, trk_w, trk_h, trk_miss} = ram_rdata;

  assign req.valid = scan_vld_q;
  assign req.slot  = iou_pkg::IDX_W'(scan_slot_q);

  iou_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_iou_unit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .det_x_i       (det_x_q),
    .det_y_i       (det_y_q),
    .det_w_i       (det_w_q),
    .det_h_i       (det_h_q),
    .trk_x_i       (trk_x),
    .trk_y_i       (trk_y),
    .trk_w_i       (trk_w),
    .trk_h_i       (trk_h),
    .new_limit_i   (new_lim_q),
    .match_limit_i (match_lim_q),
    .hit_o         (hit)
  );

  assign hit_slot = hit.slot[SW-1:0];
  assign cur_slot = rd_idx_q[SW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cars_inc = (cars_q != '1) ? cars_q + 1'b1 : cars_q;
  assign miss_new = (matched_q[cur_slot] || fresh_q[cur_slot]) ? '0 :
                    ((trk_miss != '1) ? trk_miss + 1'b1 : trk_miss);

  // Sequencer: scan, insert and end-of-frame update.
  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    res_cnt_d  = res_cnt_q;
    used_d     = used_q;
    cars_d     = cars_q;
    known_d    = known_q;
    matched_d  = matched_q;
    fresh_d    = fresh_q;
    scan_vld_d = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur_slot;
    ram_wdata  = {trk_x, trk_y, trk_w, trk_h, miss_new};
    ram_re     = 1'b0;
    ram_raddr  = cur_slot;
    load_out   = 1'b0;
    is_new_d   = 1'b0;
    full_d     = 1'b0;
    idx_d      = '0;
    ox_d       = '0;
    oy_d       = '0;
    ow_d       = '0;
    oh_d       = '0;
    omiss_d    = '0;
    vis_d      = 1'b0;
    evalid_d   = 1'b0;
    ocars_d    = cars_q;
    last_d     = 1'b1;

    // Compare results flag matches and known tracks; fresh entries are skipped.
    if (hit.valid) begin
      res_cnt_d = res_cnt_q + 1'b1;
      if (!fresh_q[hit_slot]) begin
        if (hit.hit_new) begin
          known_d = 1'b1;
        end
        if (hit.hit_match) begin
          matched_d[hit_slot] = 1'b1;
        end
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_idx_d = '0;
          if (command_i == iou_pkg::CMD_FRAME) begin
            state_d = (used_q == '0) ? ST_FEMPTY : ST_FRD;
          end else begin
            known_d   = 1'b0;
            res_cnt_d = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // One table read per cycle feeds the compare pipeline.
        if (rd_idx_q < used_q) begin
          ram_re     = 1'b1;
          scan_vld_d = 1'b1;
          rd_idx_d   = rd_idx_q + 1'b1;
        end
        if (res_cnt_q == used_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (!known_q) begin
            if (used_q == CW'(TRACK_SLOTS)) begin
              full_d = 1'b1;
            end else begin
              ram_we                     = 1'b1;
              ram_waddr                  = used_q[SW-1:0];
              ram_wdata                  = {det_x_q, det_y_q, det_w_q, det_h_q, MW'(0)};
              fresh_d[used_q[SW-1:0]]    = 1'b1;
              matched_d[used_q[SW-1:0]]  = 1'b1;
              used_d                     = used_q + 1'b1;
              cars_d                     = cars_inc;
              is_new_d                   = 1'b1;
              evalid_d                   = 1'b1;
              idx_d                      = iou_pkg::IDX_W'(used_q[SW-1:0]);
              ox_d                       = det_x_q;
              oy_d                       = det_y_q;
              ow_d                       = det_w_q;
              oh_d                       = det_h_q;
              vis_d                      = (miss_lim_q != '0);
              ocars_d                    = cars_inc;
            end
          end
        end
      end
      ST_FRD: begin
        // Read the next entry only when its result can be registered.
        if (out_free) begin
          ram_re  = 1'b1;
          state_d = ST_FWR;
        end
      end
      ST_FWR: begin
        ram_we              = 1'b1;
        matched_d[cur_slot] = 1'b0;
        fresh_d[cur_slot]   = 1'b0;
        load_out            = 1'b1;
        evalid_d            = 1'b1;
        idx_d               = iou_pkg::IDX_W'(cur_slot);
        ox_d                = trk_x;
        oy_d                = trk_y;
        ow_d                = trk_w;
        oh_d                = trk_h;
        omiss_d             = miss_new;
        vis_d               = (miss_new < miss_lim_q);
        last_d              = (rd_idx_q == used_q - 1'b1);
        if (rd_idx_q == used_q - 1'b1) begin
          state_d = ST_IDLE;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
          state_d  = ST_FRD;
        end
      end
      ST_FEMPTY: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  // State, counters, flags and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      res_cnt_q   <= '0;
      used_q      <= '0;
      cars_q      <= '0;
      known_q     <= 1'b0;
      matched_q   <= '0;
      fresh_q     <= '0;
      scan_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      res_cnt_q   <= res_cnt_d;
      used_q      <= used_d;
      cars_q      <= cars_d;
      known_q     <= known_d;
      matched_q   <= matched_d;
      fresh_q     <= fresh_d;
      scan_vld_q  <= scan_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    scan_slot_q <= cur_slot;
    if (state_q == ST_IDLE && in_valid_i) begin
      det_x_q <= box_x_i;
      det_y_q <= box_y_i;
      det_w_q <= box_width_i;
      det_h_q <= box_height_i;
    end
    if (load_out) begin
      is_new_q <= is_new_d;
      full_q   <= full_d;
      idx_q    <= idx_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      ow_q     <= ow_d;
      oh_q     <= oh_d;
      omiss_q  <= omiss_d;
      vis_q    <= vis_d;
      evalid_q <= evalid_d;
      ocars_q  <= ocars_d;
      last_q   <= last_d;
    end
  end

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_lim_q   <= iou_pkg::NEW_IOU_RST;
      match_lim_q <= iou_pkg::MATCH_IOU_RST;
      miss_lim_q  <= iou_pkg::MISS_LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iou_pkg::REG_NEW_IOU:   new_lim_q   <= cfg_data_i;
        iou_pkg::REG_MATCH_IOU: match_lim_q <= cfg_data_i;
        iou_pkg::REG_MISS_LIM:  miss_lim_q  <= cfg_data_i[MW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_new_o       = is_new_q;
  assign table_full_o   = full_q;
  assign entry_index_o  = idx_q;
  assign entry_x_o      = ox_q;
  assign entry_y_o      = oy_q;
  assign entry_width_o  = ow_q;
  assign entry_height_o = oh_q;
  assign miss_count_o   = omiss_q;
  assign visible_o      = vis_q;
  assign entry_valid_o  = evalid_q;
  assign car_total_o    = ocars_q;
  assign last_o         = last_q;

`ifndef NO_ASSERTIONS
  // The track count never exceeds the table size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(TRACK_SLOTS))
    else $error("track count exceeds table size");

  // Compare results only arrive while a detection scan is running.
  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit.valid |-> (state_q == ST_SCAN))
    else $error("compare result outside of a scan");

  // The car total only moves together with a new-track result.
  a_cars_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cars_q != $past(cars_q)) |-> (out_valid_o && is_new_o))
    else $error("car total changed without a new track");

  // A new track result always carries a table entry and never the full flag.
  a_new_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_new_o) |-> (entry_valid_o && !table_full_o && last_o))
    else $error("inconsistent new track result");
`endif

endmodule
